### hdl/pkxc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkxc_pkg
// Shared constants for the prime keystream xor cipher: register map and
// reset value of the start key.
// ----------------------------------------------------------------------------
package pkxc_pkg;

	// configuration register data width
	localparam int unsigned CFG_DATA_W = 32;

	// paddr width: word index sits in bit 2, byte offset in bits 1:0
	localparam int unsigned CFG_ADDR_W = 3;

	// word index of the start key register
	localparam logic REG_START_KEY = 1'b0;

	// start key after reset
	localparam logic [CFG_DATA_W-1:0] START_KEY_RESET = 32'd50000000;

	// low byte of the prime is the keystream byte
	localparam int unsigned BYTE_W = 8;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

### hdl/prime_keystream_xor_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_keystream_xor_cipher
// Xors each byte with the low byte of the next prime at or above a running
// candidate; the candidate then moves one past that prime.
// ----------------------------------------------------------------------------
// One word is worked at a time. From the running candidate the block walks
// upward, testing each candidate by trial division with d = 2, 3, ... while
// d*d <= candidate. The remainder comes from one shared restoring divider
// that retires one dividend bit a cycle. How long the search runs depends on
// the data. in_stall stays high from the accepted input word until the result
// is loaded into the output register, so the next input word waits for that.
// When no prime remains below 2^KEY_BITS - 1 the result is a zero byte with
// exhausted set and the candidate is left as it was. Writing start_key (byte
// address 0) also reloads the running candidate; write it only while the
// block is idle.
// ----------------------------------------------------------------------------
module prime_keystream_xor_cipher
	import pkxc_pkg::*;
#(
	parameter int unsigned KEY_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,

	// input words
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            plain_byte,

	// output words
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            cipher_byte,
	output logic                  exhausted
);

	localparam int unsigned CNT_W = $clog2(KEY_BITS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CAND = 3'd1;
	localparam logic [2:0] ST_TEST = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_REM  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	localparam logic [KEY_BITS-1:0] CAND_LIMIT = '1;

	logic [2:0]              state_q;
	logic [CFG_DATA_W-1:0]   start_key_q;
	logic [KEY_BITS-1:0]     next_cand_q;
	logic [KEY_BITS-1:0]     cand_q;
	logic [KEY_BITS-1:0]     d_q;
	logic [KEY_BITS+1:0]     sq_q;
	logic [KEY_BITS:0]       rem_q;
	logic [KEY_BITS-1:0]     sh_q;
	logic [CNT_W-1:0]        cnt_q;
	byte_t                   byte_q;
	byte_t                   res_byte_q;
	logic                    res_exh_q;
	logic                    out_valid_q;
	byte_t                   out_byte_q;
	logic                    out_exh_q;

	logic                    cfg_wr;
	logic                    in_acc;
	logic                    out_free;
	logic [KEY_BITS:0]       rem_shift;
	logic                    rem_ge;

	// configuration access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_START_KEY);
	assign prdata = (paddr[2] == REG_START_KEY) ? start_key_q : '0;

	// handshakes
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// one restoring division step
	assign rem_shift = {rem_q[KEY_BITS-1:0], sh_q[KEY_BITS-1]};
	assign rem_ge    = (rem_shift >= {1'b0, d_q});

	// start key and running candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_key_q <= START_KEY_RESET;
			next_cand_q <= KEY_BITS'(START_KEY_RESET);
		end else if (cfg_wr) begin
			start_key_q <= pwdata;
			next_cand_q <= KEY_BITS'(pwdata);
		end else if (state_q == ST_TEST && sq_q > {2'b00, cand_q}) begin
			next_cand_q <= cand_q + KEY_BITS'(1);
		end
	end

	// search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_CAND;
				ST_CAND: state_q <= (cand_q == CAND_LIMIT) ? ST_DONE : ST_TEST;
				ST_TEST: state_q <= (sq_q > {2'b00, cand_q}) ? ST_DONE : ST_DIV;
				ST_DIV:  if (cnt_q == CNT_W'(1)) state_q <= ST_REM;
				ST_REM:  state_q <= (rem_q == '0) ? ST_CAND : ST_TEST;
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: byte, candidate, divisor, square, divider and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				byte_q <= plain_byte;
				cand_q <= next_cand_q;
			end
			ST_CAND: begin
				d_q        <= KEY_BITS'(2);
				sq_q       <= (KEY_BITS + 2)'(4);
				res_byte_q <= '0;
				res_exh_q  <= 1'b1;
			end
			ST_TEST: begin
				res_byte_q <= byte_q ^ cand_q[BYTE_W-1:0];
				res_exh_q  <= 1'b0;
				rem_q      <= '0;
				sh_q       <= cand_q;
				cnt_q      <= CNT_W'(KEY_BITS);
			end
			ST_DIV: begin
				rem_q <= rem_ge ? (rem_shift - {1'b0, d_q}) : rem_shift;
				sh_q  <= {sh_q[KEY_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_REM: begin
				if (rem_q == '0) begin
					cand_q <= cand_q + KEY_BITS'(1);
				end else begin
					d_q  <= d_q + KEY_BITS'(1);
					sq_q <= sq_q + {1'b0, d_q, 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_byte_q <= res_byte_q;
			out_exh_q  <= res_exh_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign cipher_byte = out_byte_q;
	assign exhausted   = out_exh_q;

	// checks
	a_word_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("output word without a finished search");

	a_exh_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && exhausted) |-> (cipher_byte == '0))
		else $error("exhausted word carries a nonzero byte");

	a_cand_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |=> $stable(next_cand_q))
		else $error("running candidate moved during a division");

	a_div_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (d_q >= KEY_BITS'(2)))
		else $error("trial divisor below two");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REM) |-> (rem_q < {1'b0, d_q}))
		else $error("remainder not below divisor");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the prime keystream xor cipher. A predictor in the bench
// tracks the running prime candidate, searches for the next prime by trial
// division and queues the expected word for every byte that is sent. Each
// output word is checked against the oldest queued word. The bench writes
// start_key over the config port between phases while the block is idle.
// Stimulus covers the reset key, byte extremes, candidates zero and one,
// exhausted keys at the top of the range and random keys, mostly small,
// with random idle bursts on both sides and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_top;
	import pkxc_pkg::*;

	localparam int unsigned KEY_BITS = 32;
	localparam longint unsigned KEY_MASK = (64'd1 << KEY_BITS) - 64'd1;
	localparam longint unsigned CAND_LIMIT = KEY_MASK;

	typedef struct packed {
		byte_t cipher_byte;
		logic  exhausted;
	} cipher_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_stall;
	logic [7:0]            plain_byte;
	logic                  out_valid;
	logic                  out_stall;
	logic [7:0]            cipher_byte;
	logic                  exhausted;

	// predictor state and expected words
	longint unsigned prime_cand;
	cipher_word_t    pending_words[$];
	int unsigned     mismatch_count;
	bit              idle_on;
	int unsigned     stall_left;

	prime_keystream_xor_cipher #(
		.KEY_BITS(KEY_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.plain_byte(plain_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cipher_byte(cipher_byte),
		.exhausted(exhausted)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#1_000_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	// trial division, zero and one count as prime
	function automatic bit has_no_factor(longint unsigned n);
		longint unsigned d;
		for (d = 2; d <= n / d; d++) begin
			if (n % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// next prime below the limit, advances the running candidate
	function automatic cipher_word_t next_prime_word(byte_t pb);
		longint unsigned c;
		bit              found;
		cipher_word_t    w;
		c = prime_cand;
		found = 1'b0;
		w.cipher_byte = '0;
		w.exhausted = 1'b1;
		while (!found && c < CAND_LIMIT) begin
			if (has_no_factor(c)) begin
				found = 1'b1;
				w.cipher_byte = pb ^ c[7:0];
				w.exhausted = 1'b0;
				prime_cand = (c + 1) & KEY_MASK;
			end else begin
				c++;
			end
		end
		return w;
	endfunction

	// output stall in random bursts
	always @(posedge clk) begin
		if (!idle_on) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(1, 6) - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each output word with the oldest expectation
	always @(posedge clk) begin
		cipher_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				$error("output word with no expectation: cipher_byte %h exhausted %b",
					cipher_byte, exhausted);
				mismatch_count++;
			end else begin
				w = pending_words.pop_front();
				if (cipher_byte !== w.cipher_byte) begin
					$error("cipher_byte: expected %h, actual %h", w.cipher_byte, cipher_byte);
					mismatch_count++;
				end
				if (exhausted !== w.exhausted) begin
					$error("exhausted: expected %b, actual %b", w.exhausted, exhausted);
					mismatch_count++;
				end
			end
		end
	end

	// present one word, hold it until accepted
	task automatic send_word(input byte_t pb);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pending_words.push_back(next_prime_word(pb));
		in_valid <= 1'b1;
		plain_byte <= pb;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// stop sending and wait for every expected word
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// config write: setup then access phase
	task automatic write_start_key(input logic [CFG_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_START_KEY, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		prime_cand = longint'(value) & KEY_MASK;
	endtask

	// first word uses the start key left by reset
	task automatic test_reset_key();
		idle_on = 1'b1;
		send_word(8'hA5);
	endtask

	// start key of two, the smallest prime, with extreme byte patterns
	task automatic test_byte_extremes();
		drain();
		write_start_key(32'd2);
		send_word(8'h00);
		send_word(8'hFF);
		send_word(8'h55);
		send_word(8'hAA);
		send_word(8'h01);
		send_word(8'h80);
	endtask

	// candidates zero and one pass the primality test
	task automatic test_zero_one();
		drain();
		write_start_key(32'd0);
		send_word(8'h3C);
		send_word(8'hC3);
		send_word(8'h0F);
	endtask

	// no prime left: zero byte, flag set, candidate holds
	task automatic test_exhausted();
		drain();
		write_start_key(32'hFFFF_FFFE);
		send_word(8'hFF);
		send_word(8'h7E);
		send_word(8'h81);
		drain();
		write_start_key(32'hFFFF_FFFF);
		send_word(8'hFF);
		send_word(8'h00);
	endtask

	// random phases, mostly small keys so the search stays short
	task automatic test_random_keys();
		int unsigned sent;
		int unsigned n;
		int unsigned pick;
		logic [CFG_DATA_W-1:0] key;
		sent = 0;
		while (sent < 80) begin
			drain();
			pick = $urandom_range(0, 11);
			if (pick == 0)
				key = $urandom_range(0, 1) ? 32'hFFFF_FFFE : 32'hFFFF_FFFF;
			else if (pick == 1)
				key = $urandom_range(5001, 100000);
			else
				key = $urandom_range(2, 5000);
			write_start_key(key);
			n = $urandom_range(4, 12);
			repeat (n) begin
				send_word(byte_t'($urandom));
				sent++;
			end
		end
	endtask

	// full rate on both sides
	task automatic test_back_to_back();
		drain();
		idle_on = 1'b0;
		write_start_key($urandom_range(2, 3000));
		repeat (16) send_word(byte_t'($urandom));
	endtask

	// reset and test sequence
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		plain_byte = '0;
		out_stall = 1'b0;
		stall_left = 0;
		idle_on = 1'b0;
		mismatch_count = 0;
		prime_cand = longint'(START_KEY_RESET) & KEY_MASK;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_key();
		test_byte_extremes();
		test_zero_one();
		test_exhausted();
		test_random_keys();
		test_back_to_back();
		drain();

		if (mismatch_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
